// ===== hw/rtl/pgw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_pkg: shared types and constants of the page-table walker
// Item and result layouts, operation and status codes, walker states.
// ----------------------------------------------------------------------------
package pgw_pkg;

  // store size default, log2 of the number of 64-bit words
  localparam int STORE_WORDS_LOG2_DEF = 14;

  // field widths
  localparam int ROOT_W       = 17;
  localparam int FRAME_LSB    = 12;
  localparam int ROOT_FRAME_W = ROOT_W - FRAME_LSB;
  localparam int VA_W         = 48;
  localparam int IDX_W        = 14;
  localparam int ENTRY_W      = 64;
  localparam int ATTR_W       = 12;
  localparam int LEVEL_IDX_W  = 9;
  localparam int LEAF_BIT     = 7;

  // stream payload widths
  localparam int IN_TDATA_W   = 128;
  localparam int OUT_FIELDS_W = 64 + 12 + 2 + 3;
  localparam int OUT_TDATA_W  = 88;

  // front-to-back queue
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = 1;
  localparam int QUEUE_CNT_W  = 2;

  // action bit on the input stream
  localparam logic ACTION_WRITE = 1'b0;

  // classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_WALK,
    OP_NO_ROOT
  } op_t;

  // walker states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_WALK
  } bk_state_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOP_EMPTY    = 3'd1,
    ST_SECOND_EMPTY = 3'd2,
    ST_THIRD_EMPTY  = 3'd3,
    ST_LEAF_EMPTY   = 3'd4,
    ST_NO_ROOT      = 3'd5
  } walk_status_t;

  typedef enum logic [1:0] {
    PS_4K = 2'd0,
    PS_2M = 2'd1,
    PS_1G = 2'd2
  } page_size_t;

  typedef struct packed {
    op_t                     op;
    logic [ROOT_FRAME_W-1:0] root_frame;
    logic [VA_W-1:0]         virt_addr;
    logic [IDX_W-1:0]        entry_index;
    logic [ENTRY_W-1:0]      entry_value;
  } wlk_item_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] phys_base;
    logic [ATTR_W-1:0]  attributes;
    page_size_t         page_size;
    walk_status_t       walk_status;
  } wlk_result_t;

endpackage

// ===== hw/rtl/pgw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_front: input side of the page-table walker
// Holds the root register, accepts input beats and classifies each one
// as a table write, a walk or a lookup without root before queueing it.
// ----------------------------------------------------------------------------
module pgw_front
  import pgw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [ROOT_W-1:0]     cfg_wr_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tuser,
  input  logic                  clearing,
  input  logic                  q_full,
  output logic                  push,
  output wlk_item_t             push_item
);

  logic [ROOT_W-1:0] root_table_base;

  // root register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_base <= '0;
    end else if (cfg_wr_en) begin
      root_table_base <= cfg_wr_data;
    end
  end

  // no beat taken while the store is being cleared or the queue is full
  assign s_tready = !q_full && !clearing;
  assign push     = s_tvalid && s_tready;

  // classify and unpack
  always_comb begin
    push_item.root_frame  = root_table_base[ROOT_W-1:FRAME_LSB];
    push_item.virt_addr   = s_tdata[VA_W-1:0];
    push_item.entry_index = s_tdata[VA_W+IDX_W-1:VA_W];
    push_item.entry_value = s_tdata[VA_W+IDX_W+ENTRY_W-1:VA_W+IDX_W];
    if (s_tuser == ACTION_WRITE) begin
      push_item.op = OP_WRITE;
    end else if (root_table_base[ROOT_W-1:FRAME_LSB] == '0) begin
      push_item.op = OP_NO_ROOT;
    end else begin
      push_item.op = OP_WALK;
    end
  end

endmodule

// ===== hw/rtl/pgw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_queue: short item queue between front and walker
// Small register FIFO so that front and walker stall on their own.
// ----------------------------------------------------------------------------
module pgw_queue
  import pgw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  wlk_item_t push_item,
  output logic      full,
  output logic      q_valid,
  output wlk_item_t q_item,
  input  logic      pop
);

  localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

  wlk_item_t              slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue pop while empty");

endmodule

// ===== hw/rtl/pgw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_back: table store and four-level walker
// Clears the store after reset, applies table writes and walks lookups one
// level per cycle through the registered read port of the store.
// ----------------------------------------------------------------------------
module pgw_back
  import pgw_pkg::*;
#(
  parameter int STORE_WORDS_LOG2 = STORE_WORDS_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  wlk_item_t   q_item,
  output logic        q_pop,
  output logic        clearing,
  output logic        m_tvalid,
  input  logic        m_tready,
  output wlk_result_t m_result
);

  localparam int WORDS     = 1 << STORE_WORDS_LOG2;
  localparam int CAT_W     = ENTRY_W - FRAME_LSB + LEVEL_IDX_W;
  localparam int WR_CAT_W  = 32;
  localparam int ROOT_PAD  = CAT_W - ROOT_FRAME_W - LEVEL_IDX_W;

  logic [ENTRY_W-1:0]          mem [WORDS];
  logic [ENTRY_W-1:0]          rdata;
  bk_state_t                   state;
  bk_state_t                   state_next;
  logic [STORE_WORDS_LOG2-1:0] clr_cnt;
  logic [1:0]                  level;
  logic [1:0]                  level_next;
  logic [VA_W-1:0]             va;
  logic                        out_valid;
  wlk_result_t                 out_result;

  logic                        out_free;
  logic                        mem_we;
  logic [STORE_WORDS_LOG2-1:0] mem_waddr;
  logic [ENTRY_W-1:0]          mem_wdata;
  logic                        rd_en;
  logic [STORE_WORDS_LOG2-1:0] rd_addr;
  logic                        fin;
  wlk_result_t                 fin_result;
  logic [LEVEL_IDX_W-1:0]      next_idx;
  logic [CAT_W-1:0]            root_cat;
  logic [CAT_W-1:0]            entry_cat;
  logic [WR_CAT_W-1:0]         wr_cat;
  logic                        e_zero;
  logic                        is_leaf;
  logic                        walk_done;

  function automatic wlk_result_t leaf_result(logic [ENTRY_W-1:0] e, page_size_t size);
    wlk_result_t r;
    r.phys_base   = {e[ENTRY_W-1:FRAME_LSB], {FRAME_LSB{1'b0}}};
    r.attributes  = {e[ATTR_W-1:LEAF_BIT+1], 1'b0, e[LEAF_BIT-1:0]};
    r.page_size   = size;
    r.walk_status = ST_OK;
    return r;
  endfunction

  function automatic wlk_result_t fail_result(walk_status_t status);
    wlk_result_t r;
    r.phys_base   = '0;
    r.attributes  = '0;
    r.page_size   = PS_4K;
    r.walk_status = status;
    return r;
  endfunction

  assign out_free = !out_valid || m_tready;
  assign clearing = (state == BK_CLEAR);
  assign m_tvalid = out_valid;
  assign m_result = out_result;

  // word addresses: the table frame sits above the nine-bit index
  always_comb begin
    case (level)
      2'd0:    next_idx = va[38:30];
      2'd1:    next_idx = va[29:21];
      default: next_idx = va[20:12];
    endcase
  end

  assign root_cat  = {{ROOT_PAD{1'b0}}, q_item.root_frame, q_item.virt_addr[47:39]};
  assign entry_cat = {rdata[ENTRY_W-1:FRAME_LSB], next_idx};
  assign wr_cat    = {{(WR_CAT_W-IDX_W){1'b0}}, q_item.entry_index};

  // entry checks on the word just read
  assign e_zero    = (rdata == '0);
  assign is_leaf   = (level == 2'd3) ||
                     (rdata[LEAF_BIT] && (level == 2'd1 || level == 2'd2));
  assign walk_done = e_zero || is_leaf;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (clr_cnt == '1) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_pop && q_item.op == OP_WALK) state_next = BK_WALK;
      end
      BK_WALK: begin
        if (fin) state_next = BK_IDLE;
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt;
    mem_wdata  = '0;
    rd_en      = 1'b0;
    rd_addr    = root_cat[STORE_WORDS_LOG2-1:0];
    fin        = 1'b0;
    fin_result = fail_result(ST_NO_ROOT);
    level_next = level;
    case (state)
      BK_CLEAR: begin
        mem_we = 1'b1;
      end
      BK_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_WRITE: begin
              q_pop     = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = wr_cat[STORE_WORDS_LOG2-1:0];
              mem_wdata = q_item.entry_value;
            end
            OP_WALK: begin
              q_pop      = 1'b1;
              rd_en      = 1'b1;
              level_next = 2'd0;
            end
            OP_NO_ROOT: begin
              if (out_free) begin
                q_pop = 1'b1;
                fin   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      BK_WALK: begin
        if (walk_done) begin
          // read data holds until the result register frees up
          fin = out_free;
          if (e_zero) begin
            case (level)
              2'd0:    fin_result = fail_result(ST_TOP_EMPTY);
              2'd1:    fin_result = fail_result(ST_SECOND_EMPTY);
              2'd2:    fin_result = fail_result(ST_THIRD_EMPTY);
              default: fin_result = fail_result(ST_LEAF_EMPTY);
            endcase
          end else begin
            case (level)
              2'd1:    fin_result = leaf_result(rdata, PS_1G);
              2'd2:    fin_result = leaf_result(rdata, PS_2M);
              default: fin_result = leaf_result(rdata, PS_4K);
            endcase
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = entry_cat[STORE_WORDS_LOG2-1:0];
          level_next = level + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // state, clear counter, level and address
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CLEAR;
      clr_cnt <= '0;
      level   <= '0;
    end else begin
      state <= state_next;
      level <= level_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      va <= q_item.virt_addr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_result <= fin_result;
    end
  end

  // table store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("item taken during store clear");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    fin |-> out_free)
    else $error("result register overwritten");
  a_no_read_write_clash: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !mem_we)
    else $error("store read and write in one cycle");
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CLEAR && state_next == BK_IDLE) |-> (clr_cnt == '1))
    else $error("store clear left early");

endmodule

// ===== hw/rtl/four_level_page_table_walker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top: four-level page-table walker
// Table store with write items and four-level lookups from a root register.
//
// Usage:
//   s_* carries items: s_tuser is the action (0 write entry, 1 lookup).
//   m_* carries one result beat per lookup; writes give no beat.
//   cfg_wr_en / cfg_wr_data load the root table byte address.
//   After reset the store is swept to zero, one word per cycle, over all
//   2**STORE_WORDS_LOG2 words (16384 by default); s_tready stays low then.
//   A write is applied as it leaves the queue. A lookup starts with the
//   top-level read, then reads one table level after another, at most four
//   levels in all; the store's single registered read port allows one
//   dependent read per level. A lookup without root is answered as it
//   leaves the queue, once the result register is free.
//   A two-beat queue sits between input and walker, and the result sits in
//   an output register: while m_tready is low the walker holds its last
//   read and the queue keeps taking beats until it is full.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top
  import pgw_pkg::*;
#(
  parameter int STORE_WORDS_LOG2 = STORE_WORDS_LOG2_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [ROOT_W-1:0]      cfg_wr_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // virt_addr[47:0], entry_index[61:48], entry_value[125:62], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // action
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // phys_base[63:0], attributes[75:64], page_size[77:76],
  // walk_status[80:78], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic        clearing;
  logic        q_full;
  logic        push;
  wlk_item_t   push_item;
  logic        q_valid;
  wlk_item_t   q_item;
  logic        q_pop;
  wlk_result_t result;

  pgw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .clearing    (clearing),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  pgw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop)
  );

  pgw_back #(
    .STORE_WORDS_LOG2 (STORE_WORDS_LOG2)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (result)
  );

  // pack the result beat, first field lowest
  assign m_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, result.walk_status,
                    result.page_size, result.attributes, result.phys_base};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for four_level_page_table_walker_top
// Table writes and lookups go in as stream beats. A mirror of the table store
// and of the root register predicts each lookup, and result beats are checked
// in order. The sender idles in bursts, and the receiver stalls on a pattern
// of its own with one long hold. Directed walks reach every exit status and
// page size. Random walks are built entry by entry, with noise in between.
// ----------------------------------------------------------------------------
module tb;
  import pgw_pkg::*;

  localparam logic ACTION_LOOKUP = ~ACTION_WRITE;
  localparam int   STALL_LIMIT   = 70000;
  localparam int   LONG_HOLD     = 400;
  localparam int   DRAIN_CYCLES  = 12;

  // one input beat before packing
  typedef struct packed {
    logic        action;
    logic [47:0] va;
    logic [13:0] index;
    logic [63:0] value;
  } table_req_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [ROOT_W-1:0]      cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // mirror of the block state
  logic [63:0]       table_mirror [0:16383];
  logic [ROOT_W-1:0] root_mirror = '0;

  table_req_t  req_backlog[$];
  wlk_result_t expected_walks[$];
  table_req_t  req_on_bus;
  int          items_queued = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          error_count = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;
  logic [31:0] rx_cycle = '0;

  four_level_page_table_walker_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < 16384; i++) table_mirror[i] = '0;
  end

  // word of a table entry: frame byte address over 8 plus index, wrapped
  function automatic logic [13:0] word_of(logic [63:0] tbl, logic [8:0] idx);
    logic [63:0] w;
    w = ((tbl & ~64'hfff) >> 3) + 64'(idx);
    return w[13:0];
  endfunction

  function automatic wlk_result_t leaf_result(logic [63:0] e, page_size_t ps);
    wlk_result_t r;
    r = '0;
    r.phys_base  = {e[63:12], 12'h000};
    r.attributes = e[11:0] & ~12'h080;
    r.page_size  = ps;
    r.walk_status = ST_OK;
    return r;
  endfunction

  // expected outcome of a four-level walk from the mirrored root
  function automatic wlk_result_t predict_walk(logic [47:0] va);
    wlk_result_t r;
    logic [63:0] e;
    r = '0;
    if (root_mirror[16:12] == '0) begin
      r.walk_status = ST_NO_ROOT;
      return r;
    end
    e = table_mirror[word_of(64'(root_mirror), va[47:39])];
    if (e == '0) begin
      r.walk_status = ST_TOP_EMPTY;
      return r;
    end
    e = table_mirror[word_of(e, va[38:30])];
    if (e == '0) begin
      r.walk_status = ST_SECOND_EMPTY;
      return r;
    end
    if (e[LEAF_BIT]) return leaf_result(e, PS_1G);
    e = table_mirror[word_of(e, va[29:21])];
    if (e == '0) begin
      r.walk_status = ST_THIRD_EMPTY;
      return r;
    end
    if (e[LEAF_BIT]) return leaf_result(e, PS_2M);
    e = table_mirror[word_of(e, va[20:12])];
    if (e == '0) begin
      r.walk_status = ST_LEAF_EMPTY;
      return r;
    end
    return leaf_result(e, PS_4K);
  endfunction

  // random link to a next-level table, sometimes with high address bits
  function automatic logic [63:0] table_link(bit top);
    logic [63:0] e;
    e = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) e[63:17] = '0;
    if (!top) e[LEAF_BIT] = 1'b0;
    return e;
  endfunction

  function automatic logic [63:0] leaf_entry();
    logic [63:0] e;
    e = {$urandom, $urandom};
    e[LEAF_BIT] = 1'b1;
    return e;
  endfunction

  task automatic flag_error(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic push_write(input logic [13:0] idx, input logic [63:0] val);
    table_req_t t;
    t.action = ACTION_WRITE;
    t.va     = 48'({$urandom, $urandom});
    t.index  = idx;
    t.value  = val;
    req_backlog.push_back(t);
    items_queued++;
  endtask

  task automatic push_lookup(input logic [47:0] va);
    table_req_t t;
    t.action = ACTION_LOOKUP;
    t.va     = va;
    t.index  = 14'($urandom);
    t.value  = {$urandom, $urandom};
    req_backlog.push_back(t);
    items_queued++;
  endtask

  // root write, only while the walker is idle
  task automatic set_root(input logic [ROOT_W-1:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    root_mirror = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender drained, every lookup answered, then let trailing writes retire
  task automatic wait_idle();
    do @(posedge clk);
    while (req_backlog.size() != 0 || s_tvalid || expected_walks.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly walks built entry by entry with random content, plus noise
  task automatic gen_random(input int target);
    logic [47:0] va;
    logic [47:0] last_va;
    logic [63:0] e1, e2, e3, e4;
    int          kind;
    int          pick;
    bit          have_last;
    have_last = 1'b0;
    last_va = '0;
    while (items_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 12 && have_last) begin
        // neighbor of the last walk, shares the upper tables
        push_lookup({last_va[47:21], 21'($urandom)});
      end else if (pick < 72) begin
        va   = 48'({$urandom, $urandom});
        kind = $urandom_range(0, 9);
        e1 = (kind == 0) ? 64'h0 : table_link(1'b1);
        push_write(word_of(64'(root_mirror), va[47:39]), e1);
        if (kind >= 1) begin
          if (kind == 1) e2 = '0;
          else if (kind == 4 || kind == 5) e2 = leaf_entry();
          else e2 = table_link(1'b0);
          push_write(word_of(e1, va[38:30]), e2);
        end
        if (kind >= 2 && kind != 4 && kind != 5) begin
          if (kind == 2) e3 = '0;
          else if (kind == 6 || kind == 7) e3 = leaf_entry();
          else e3 = table_link(1'b0);
          push_write(word_of(e2, va[29:21]), e3);
        end
        if (kind == 3 || kind >= 8) begin
          e4 = (kind == 3) ? 64'h0 : {$urandom, $urandom};
          push_write(word_of(e3, va[20:12]), e4);
        end
        push_lookup(va);
        last_va   = va;
        have_last = 1'b1;
      end else if (pick < 88) begin
        push_write(14'($urandom), ($urandom_range(0, 4) == 0) ? 64'h0 : {$urandom, $urandom});
      end else begin
        push_lookup(48'({$urandom, $urandom}));
      end
    end
  endtask

  // stimulus sequence
  initial begin
    logic [ROOT_W-1:0] phase_root;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // no root after reset, value extremes on word zero
    push_lookup(48'h0);
    push_write(14'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    push_write(14'd0, 64'h0);
    wait_idle();

    // root at the top frame, low bits set and ignored
    set_root(17'h1ffff);
    push_lookup(48'h0);
    push_lookup(48'hFFFF_FFFF_FFFF);
    // top entry with high bits and bit 7 set, links to frame 1
    push_write(14'd16383, 64'hFFFF_FFFF_FFE0_1FFF);
    push_lookup(48'hFFFF_FFFF_FFFF);
    push_write(14'd1023, 64'h8000_0000_0000_2001);
    push_lookup(48'hFFFF_FFFF_FFFF);
    push_write(14'd1535, 64'h0000_0000_0000_3003);
    push_lookup(48'hFFFF_FFFF_FFFF);
    // last-level entry with bit 7 set stays a 4 KiB page
    push_write(14'd2047, 64'hFFFF_FFFF_FFFF_FFFF);
    push_lookup(48'hFFFF_FFFF_FFFF);
    // 1 GiB leaf at the second level
    push_write(14'd1023, 64'h1234_5678_9ABC_D0C3);
    push_lookup(48'hFFFF_FFFF_FFFF);
    // 2 MiB leaf at the third level
    push_write(14'd1023, 64'h8000_0000_0000_2001);
    push_write(14'd1535, 64'h0000_00FF_FFFF_F081);
    push_lookup(48'hFFFF_FFFF_FFFF);
    // empty last level again
    push_write(14'd2047, 64'h0);
    push_write(14'd1535, 64'h0000_0000_0000_3003);
    push_lookup(48'hFFFF_FFFF_FFFF);
    wait_idle();

    // only low bits set: still no root
    set_root(17'h00fff);
    push_lookup(48'hFFFF_FFFF_FFFF);
    push_lookup(48'h8000_0000_1000);
    wait_idle();

    // random phases over several roots, ending with none
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: phase_root = 17'h01000;
        1: phase_root = {5'($urandom_range(1, 31)), 12'($urandom)};
        2: phase_root = {5'($urandom_range(1, 31)), 12'($urandom)};
        default: phase_root = 17'h00000;
      endcase
      set_root(phase_root);
      gen_random(items_queued + ((p == 3) ? 40 : 300));
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("four_level_page_table_walker_top test passed");
    end else begin
      $display("four_level_page_table_walker_top test failed");
    end
    $finish;
  end

  // input driver: bursts of beats with random gaps
  always @(posedge clk) begin : item_driver
    logic       offer;
    table_req_t nxt;
    if (!rst) begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        if (req_on_bus.action == ACTION_WRITE) begin
          table_mirror[req_on_bus.index] = req_on_bus.value;
        end else begin
          expected_walks.push_back(predict_walk(req_on_bus.va));
        end
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_backlog.size() > 0) begin
          nxt = req_backlog.pop_front();
          req_on_bus = nxt;
          s_tdata <= {2'b00, nxt.value, nxt.index, nxt.va};
          s_tuser <= nxt.action;
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
      s_tvalid <= offer;
    end
  end

  // result sink: stall pattern by window, one long hold
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!long_hold_done && results_seen >= 100) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD;
      m_tready       <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= 1'($urandom_range(0, 1));
        2'd2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ((rx_cycle % 7) >= 3);
      endcase
    end
  end

  // result monitor: compare each beat with the oldest expected walk
  always @(posedge clk) begin : result_monitor
    wlk_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (expected_walks.size() == 0) begin
        flag_error($sformatf("result beat with no lookup pending, tdata %h", m_tdata));
      end else begin
        want = expected_walks.pop_front();
        if (m_tdata[63:0] !== want.phys_base)
          flag_error($sformatf("phys_base got %h want %h", m_tdata[63:0], want.phys_base));
        if (m_tdata[75:64] !== want.attributes)
          flag_error($sformatf("attributes got %h want %h", m_tdata[75:64], want.attributes));
        if (m_tdata[77:76] !== want.page_size)
          flag_error($sformatf("page_size got %0d want %0d", m_tdata[77:76], want.page_size));
        if (m_tdata[80:78] !== want.walk_status)
          flag_error($sformatf("walk_status got %0d want %0d", m_tdata[80:78],
                               want.walk_status));
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("four_level_page_table_walker_top test failed");
      $finish;
    end
  end

endmodule
